@@ hw/rtl/xorshift_range_chance_generator_macros.svh @@
// assertion helpers for the range and chance generator
`ifndef XORSHIFT_RANGE_CHANCE_GENERATOR_MACROS_SVH
`define XORSHIFT_RANGE_CHANCE_GENERATOR_MACROS_SVH

// same-cycle implication, inactive during reset
`define XRCG_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, inactive during reset
`define XRCG_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/xrcg_pkg.sv @@
package xrcg_pkg;

    localparam int WORD_W   = 32;
    localparam int PCT_W    = 7;
    localparam int STEPS    = WORD_W;
    localparam int CNT_W    = $clog2(STEPS);

    localparam int SH_A     = 13;
    localparam int SH_B     = 17;
    localparam int SH_C     = 5;

    localparam logic [PCT_W:0]      PCT_MOD  = (PCT_W + 1)'(100);
    localparam logic [WORD_W-1:0]   SEED_ONE = WORD_W'(1);
    localparam logic [CNT_W-1:0]    CNT_LAST = CNT_W'(STEPS - 1);

    typedef struct packed {
        logic signed [WORD_W-1:0] range_low;
        logic signed [WORD_W-1:0] range_high;
        logic [PCT_W-1:0]         percent;
    } t_req;

    typedef struct packed {
        logic [WORD_W-1:0]        raw_word;
        logic signed [WORD_W-1:0] ranged_value;
        logic                     hit;
    } t_rsp;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic [WORD_W-1:0] f_xorshift(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        a = x ^ (x << SH_A);
        b = a ^ (a >> SH_B);
        return b ^ (b << SH_C);
    endfunction

endpackage

@@ hw/rtl/xrcg_mod_unit.sv @@
module xrcg_mod_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [xrcg_pkg::WORD_W-1:0]   i_dividend,
    input  logic [xrcg_pkg::WORD_W-1:0]   i_divisor,
    output xrcg_pkg::t_div_stat           o_stat,
    output logic [xrcg_pkg::WORD_W-1:0]   o_rem,
    output logic [xrcg_pkg::PCT_W-1:0]    o_rem_pct
);
    import xrcg_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [CNT_W-1:0]    r_cnt;
    logic [WORD_W-1:0]   r_dvd;
    logic [WORD_W-1:0]   r_div;
    logic [WORD_W-1:0]   r_rem;
    logic [PCT_W-1:0]    r_pct;

    logic [WORD_W-1:0]   n_rem;
    logic [PCT_W-1:0]    n_pct;
    logic [WORD_W:0]     w_trial;
    logic [PCT_W:0]      w_trial_pct;

    always_comb begin
        w_trial     = {r_rem, r_dvd[WORD_W-1]};
        w_trial_pct = {r_pct, r_dvd[WORD_W-1]};
        if (w_trial >= {1'b0, r_div}) begin
            n_rem = WORD_W'(w_trial - {1'b0, r_div});
        end else begin
            n_rem = w_trial[WORD_W-1:0];
        end
        if (w_trial_pct >= PCT_MOD) begin
            n_pct = PCT_W'(w_trial_pct - PCT_MOD);
        end else begin
            n_pct = w_trial_pct[PCT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_LAST);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
            r_pct <= '0;
        end else if (r_busy) begin
            r_dvd <= r_dvd << 1;
            r_rem <= n_rem;
            r_pct <= n_pct;
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_rem       = r_rem;
    assign o_rem_pct   = r_pct;

endmodule

@@ hw/rtl/xorshift_range_chance_generator.sv @@
// Range and chance random generator on a 32-bit xorshift core.
// Request channel: i_valid / o_ready with i_req (range_low, range_high, percent).
// Each accepted request takes one xorshift32 step of the state; a seed write wins.
// Response channel: o_valid / i_ready with o_rsp (raw_word, ranged_value, hit).
// ranged_value = range_low + raw_word mod (range_high - range_low + 1), all
// 32-bit wrapping; a span of zero gives range_low + raw_word. hit is set when
// raw_word mod 100 is below percent.
// Both remainders come from one shared restoring divider, one quotient bit per
// cycle; the result is loaded into the response register when the divider is
// done, and the state returns to idle on that edge, so a new request is taken
// only after the previous result has landed.
// One request is in flight at a time: o_ready is low while the divider runs.
// A response waiting in the output register does not block the next request;
// if the receiver stalls, a finished result holds in the divider until the
// output register frees up.
// Config channel: i_cfg_valid / o_cfg_ready with i_cfg_seed loads the state;
// a zero seed loads 1. Write only while idle.
// Reset: state becomes 1, no response pending, ready to accept.
module xorshift_range_chance_generator (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  xrcg_pkg::t_req                i_req,
    output logic                          o_valid,
    input  logic                          i_ready,
    output xrcg_pkg::t_rsp                o_rsp,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [xrcg_pkg::WORD_W-1:0]   i_cfg_seed
);
    import xrcg_pkg::*;
    `include "xorshift_range_chance_generator_macros.svh"

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;

    logic [1:0]               r_fsm;
    logic [1:0]               n_fsm;
    logic [WORD_W-1:0]        r_gen;
    logic [WORD_W-1:0]        r_word;
    logic signed [WORD_W-1:0] r_low;
    logic [PCT_W-1:0]         r_pct;
    logic                     r_out_valid;
    t_rsp                     r_rsp;

    logic                     w_in_acc;
    logic                     w_out_free;
    logic                     w_load;
    logic [WORD_W-1:0]        w_next_word;
    logic [WORD_W-1:0]        w_span;
    t_div_stat                w_stat;
    logic [WORD_W-1:0]        w_rem;
    logic [PCT_W-1:0]         w_rem_pct;

    assign w_in_acc    = i_valid && o_ready;
    assign w_out_free  = !r_out_valid || i_ready;
    assign w_next_word = f_xorshift(r_gen);
    assign w_span      = WORD_W'(i_req.range_high - i_req.range_low + WORD_W'(1));

    xrcg_mod_unit u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_in_acc),
        .i_dividend (w_next_word),
        .i_divisor  (w_span),
        .o_stat     (w_stat),
        .o_rem      (w_rem),
        .o_rem_pct  (w_rem_pct)
    );

    always_comb begin
        n_fsm  = r_fsm;
        w_load = 1'b0;
        case (r_fsm)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_fsm = ST_RUN;
                end
            end
            ST_RUN: begin
                if (w_stat.done) begin
                    if (w_out_free) begin
                        w_load = 1'b1;
                        n_fsm  = ST_IDLE;
                    end else begin
                        n_fsm = ST_WAIT;
                    end
                end
            end
            ST_WAIT: begin
                if (w_out_free) begin
                    w_load = 1'b1;
                    n_fsm  = ST_IDLE;
                end
            end
            default: begin
                n_fsm = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm       <= ST_IDLE;
            r_gen       <= SEED_ONE;
            r_out_valid <= 1'b0;
        end else begin
            r_fsm <= n_fsm;
            if (i_cfg_valid && o_cfg_ready) begin
                r_gen <= (i_cfg_seed == '0) ? SEED_ONE : i_cfg_seed;
            end else if (w_in_acc) begin
                r_gen <= w_next_word;
            end
            if (w_load) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_word <= w_next_word;
            r_low  <= i_req.range_low;
            r_pct  <= i_req.percent;
        end
        if (w_load) begin
            r_rsp.raw_word     <= r_word;
            r_rsp.ranged_value <= WORD_W'(r_low + w_rem);
            r_rsp.hit          <= (w_rem_pct < r_pct);
        end
    end

    assign o_ready     = (r_fsm == ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign o_valid     = r_out_valid;
    assign o_rsp       = r_rsp;

    `XRCG_ASSERT_NEXT(a_start_runs, i_clk, i_rst_n, w_in_acc, (r_fsm == ST_RUN) && w_stat.busy, "request accepted but divider not running")
    `XRCG_ASSERT_NOW(a_done_in_run, i_clk, i_rst_n, w_stat.done, r_fsm == ST_RUN, "divider finished outside run state")
    `XRCG_ASSERT_NOW(a_ready_idle_div, i_clk, i_rst_n, o_ready, !w_stat.busy, "ready while divider busy")
    `XRCG_ASSERT_NOW(a_state_nonzero, i_clk, i_rst_n, 1'b1, r_gen != '0, "generator state is zero")

endmodule

@@ sim/tb_xorshift_range_chance_generator.sv @@
`timescale 1ns / 1ps

module tb_xorshift_range_chance_generator;
    import xrcg_pkg::*;

    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int PHASE_ITEMS    = 190;

    typedef enum int {RX_ALWAYS, RX_HALF, RX_SPARSE, RX_TOGGLE} t_rx_mode;

    class draw_checker;
        logic [WORD_W-1:0] gen_state;
        t_rsp              expected_draws[$];
        int                failures;

        function new();
            gen_state = SEED_ONE;
            failures  = 0;
        endfunction

        task flag_mismatch(string what);
            $display("%0t: mismatch: %s", $time, what);
            failures++;
        endtask

        function void load_seed(logic [WORD_W-1:0] seed);
            gen_state = (seed == '0) ? SEED_ONE : seed;
        endfunction

        function int pending();
            return expected_draws.size();
        endfunction

        function void predict_draw(t_req r);
            logic [WORD_W-1:0] x;
            logic [WORD_W-1:0] lo;
            logic [WORD_W-1:0] hi;
            logic [WORD_W-1:0] span;
            logic [WORD_W-1:0] pct;
            t_rsp              e;
            x = gen_state;
            x = x ^ (x << 13);
            x = x ^ (x >> 17);
            x = x ^ (x << 5);
            gen_state = x;
            lo   = r.range_low;
            hi   = r.range_high;
            pct  = {{(WORD_W - PCT_W){1'b0}}, r.percent};
            span = hi - lo + 32'd1;
            e.raw_word     = x;
            e.ranged_value = (span == '0) ? lo + x : lo + (x % span);
            e.hit          = ((x % 32'd100) < pct);
            expected_draws.push_back(e);
        endfunction

        task check_draw(t_rsp got);
            t_rsp e;
            if (expected_draws.size() == 0) begin
                flag_mismatch($sformatf("unexpected response %h", got));
                return;
            end
            e = expected_draws.pop_front();
            if (got.raw_word !== e.raw_word)
                flag_mismatch($sformatf("raw_word got %h expected %h",
                                        got.raw_word, e.raw_word));
            if (got.ranged_value !== e.ranged_value)
                flag_mismatch($sformatf("ranged_value got %h expected %h",
                                        got.ranged_value, e.ranged_value));
            if (got.hit !== e.hit)
                flag_mismatch($sformatf("hit got %b expected %b (raw %h)",
                                        got.hit, e.hit, e.raw_word));
        endtask
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_ready;
    t_req              i_req;
    logic              o_valid;
    logic              i_ready;
    t_rsp              o_rsp;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [WORD_W-1:0] i_cfg_seed;

    draw_checker chk = new();
    int          holds_asked = 0;
    int          holds_done  = 0;
    int          quiet_cycles = 0;

    xorshift_range_chance_generator dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_req       (i_req),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_rsp       (o_rsp),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_seed  (i_cfg_seed)
    );

    initial begin
        i_clk       = 1'b0;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_req       = '0;
        i_ready     = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_seed  = '0;
    end

    always #2 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && o_ready)
                chk.predict_draw(i_req);
            if (o_valid && i_ready)
                chk.check_draw(o_rsp);
            if (i_cfg_valid && o_cfg_ready)
                chk.load_seed(i_cfg_seed);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_valid && o_ready) || (o_valid && i_ready)
                || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired with %0d responses outstanding",
                     $time, chk.pending());
            $display("tb_xorshift_range_chance_generator NOT OK");
            $finish;
        end
    end

    // receiver: own stall pattern, long hold-off on demand
    initial begin : rx_pattern
        t_rx_mode mode;
        int       left;
        int       hold;
        mode = RX_ALWAYS;
        left = 0;
        hold = 0;
        forever begin
            @(negedge i_clk);
            if (holds_done != holds_asked) begin
                hold       = HOLD_CYCLES;
                holds_done = holds_asked;
            end
            if (hold > 0) begin
                hold--;
                i_ready <= 1'b0;
            end else begin
                if (left == 0) begin
                    mode = t_rx_mode'($urandom_range(0, 3));
                    left = $urandom_range(5, 120);
                end
                left--;
                case (mode)
                    RX_ALWAYS: i_ready <= 1'b1;
                    RX_HALF:   i_ready <= ($urandom_range(0, 1) == 1);
                    RX_SPARSE: i_ready <= ($urandom_range(0, 3) == 0);
                    default:   i_ready <= ~i_ready;
                endcase
            end
        end
    end

    task automatic send_request(input t_req r);
        @(negedge i_clk);
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (!o_ready);
    endtask

    task automatic idle_gap(input int n);
        @(negedge i_clk);
        i_valid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (chk.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_seed(input logic [WORD_W-1:0] seed);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_seed  <= seed;
        do @(posedge i_clk); while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    function automatic t_req make_request(input logic [31:0] lo, input logic [31:0] hi,
                                          input logic [PCT_W-1:0] pct);
        t_req r;
        r.range_low  = lo;
        r.range_high = hi;
        r.percent    = pct;
        return r;
    endfunction

    function automatic t_req random_request();
        logic [31:0] lo;
        logic [31:0] hi;
        logic [PCT_W-1:0] pct;
        lo = $urandom;
        case ($urandom_range(0, 7))
            0, 1: hi = lo + $urandom_range(0, 200);
            2:    hi = lo + $urandom_range(0, 65535);
            3:    hi = $urandom;
            4:    hi = lo - 32'd1;
            5: begin
                lo = ($urandom_range(0, 1) == 1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
                hi = $urandom;
            end
            6:    hi = lo;
            default: hi = lo + ($urandom | 32'h8000_0000);
        endcase
        if ($urandom_range(0, 9) == 0)
            pct = PCT_W'($urandom_range(101, 127));
        else
            pct = PCT_W'($urandom_range(0, 100));
        return make_request(lo, hi, pct);
    endfunction

    task automatic run_random(input int n);
        int sent;
        int burst;
        sent = 0;
        while (sent < n) begin
            burst = $urandom_range(1, 12);
            repeat (burst) begin
                send_request(random_request());
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
                idle_gap($urandom_range(1, 30));
        end
    endtask

    initial begin : main_flow
        t_req        directed[$];
        logic [31:0] seeds[5];
        seeds = '{32'h0, 32'hFFFF_FFFF, 32'h8000_0000, $urandom, 32'h1};

        directed.push_back(make_request(32'h0, 32'h0, 7'd0));
        directed.push_back(make_request(32'h8000_0000, 32'h7FFF_FFFF, 7'd100));
        directed.push_back(make_request(32'h0, 32'hFFFF_FFFF, 7'd127));
        directed.push_back(make_request(32'd1, 32'd0, 7'd127));
        directed.push_back(make_request(32'd100, -32'sd100, 7'd101));
        directed.push_back(make_request(32'h7FFF_FFFF, 32'h8000_0000, 7'd0));
        directed.push_back(make_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 7'd50));
        directed.push_back(make_request(32'h8000_0000, 32'h8000_0000, 7'd1));
        directed.push_back(make_request(32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd99));
        directed.push_back(make_request(-32'sd10, 32'd10, 7'd64));
        directed.push_back(make_request(32'h0, 32'd99, 7'd100));
        directed.push_back(make_request(32'h0, 32'd1, 7'd100));
        directed.push_back(make_request(32'h0, 32'h7FFF_FFFE, 7'd63));
        directed.push_back(make_request(32'hAAAA_AAAA, 32'h5555_5555, 7'h2A));
        directed.push_back(make_request(32'h5555_5555, 32'hAAAA_AAAA, 7'h55));
        directed.push_back(make_request(32'h8000_0000, 32'hFFFF_FFFF, 7'd1));
        directed.push_back(make_request(32'h0, 32'h7FFF_FFFF, 7'd99));
        directed.push_back(make_request(32'hFFFF_FFFF, 32'h0, 7'd101));

        repeat (8) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) begin
            send_request(directed[i]);
            if (i % 3 == 2)
                idle_gap($urandom_range(1, 6));
        end
        idle_gap(1);
        wait_drained();

        foreach (seeds[p]) begin
            write_seed(seeds[p]);
            if (p == 1)
                holds_asked++;
            run_random(PHASE_ITEMS);
            idle_gap(1);
            wait_drained();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (chk.pending() != 0)
            chk.flag_mismatch($sformatf("%0d responses never arrived", chk.pending()));

        if (chk.failures == 0)
            $display("tb_xorshift_range_chance_generator OK");
        else
            $display("tb_xorshift_range_chance_generator NOT OK");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+hw/rtl
hw/rtl/xrcg_pkg.sv
hw/rtl/xrcg_mod_unit.sv
hw/rtl/xorshift_range_chance_generator.sv
sim/tb_xorshift_range_chance_generator.sv
